@@ hw/rtl/blm_pkg.sv @@
package blm_pkg;

  localparam int ROW_COUNT   = 8;
  localparam int COL_COUNT   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] ACT_SCAN     = 3'd0;
  localparam logic [2:0] ACT_SET_PIN  = 3'd1;
  localparam logic [2:0] ACT_SET_ROW  = 3'd2;
  localparam logic [2:0] ACT_DRAIN    = 3'd3;
  localparam logic [2:0] ACT_READ_PIN = 3'd4;

  localparam logic CFG_RELOAD   = 1'b0;
  localparam logic CFG_REVERSED = 1'b1;

  localparam logic [7:0] RELOAD_RESET = 8'd10;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SCAN,
    CMD_SET_PIN,
    CMD_SET_ROW,
    CMD_DRAIN,
    CMD_READ_PIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] sample;
    logic [2:0] row;
    logic [2:0] col;
    logic       led_bit;
    logic [7:0] row_value;
    logic       in_range;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } back_state_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < COL_COUNT; i++) begin
      r[COL_COUNT - 1 - i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [2:0] map_col(input logic rev, input logic [2:0] row,
                                         input logic [2:0] col);
    if (rev && row[2]) begin
      return 3'd7 - col;
    end
    return col;
  endfunction

endpackage

@@ hw/rtl/blm_front.sv @@
module blm_front
  import blm_pkg::*;
(
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] action,
  input  logic [7:0] column_sample,
  input  logic [5:0] led_index,
  input  logic       led_value,
  input  logic [2:0] row_index,
  input  logic [7:0] row_value,
  input  logic       reversed,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       cmd
);

  logic [2:0] pin_row;

  assign pin_row = led_index[5:3];

  always_comb begin
    cmd           = '0;
    cmd.kind      = CMD_NOP;
    cmd.sample    = column_sample;
    cmd.led_bit   = led_value;
    cmd.row_value = row_value;
    unique case (action)
      ACT_SCAN: begin
        cmd.kind = CMD_SCAN;
      end
      ACT_SET_PIN, ACT_READ_PIN: begin
        cmd.kind     = (action == ACT_SET_PIN) ? CMD_SET_PIN : CMD_READ_PIN;
        cmd.row      = pin_row;
        cmd.col      = map_col(reversed, pin_row, led_index[2:0]);
        cmd.in_range = ({1'b0, pin_row} < 4'(ROW_COUNT));
      end
      ACT_SET_ROW: begin
        cmd.kind      = CMD_SET_ROW;
        cmd.row       = row_index;
        cmd.in_range  = ({1'b0, row_index} < 4'(ROW_COUNT));
        cmd.row_value = (reversed && row_index[2]) ? reverse8(row_value) : row_value;
      end
      ACT_DRAIN: begin
        cmd.kind = CMD_DRAIN;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full && (cmd.kind != CMD_NOP);

endmodule

@@ hw/rtl/blm_queue.sv @@
module blm_queue
  import blm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t               entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_pop;

  assign full       = (count == COUNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/blm_back.sv @@
module blm_back
  import blm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       pop,
  input  logic [7:0] reload,
  input  logic       reversed,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] row_select,
  output logic [7:0] led_columns,
  output logic       event_valid,
  output logic [5:0] button_index,
  output logic       button_level,
  output logic       read_data,
  output logic       last
);

  localparam logic [2:0] ROW_LAST = 3'(ROW_COUNT - 1);

  back_state_t state;
  back_state_t state_next;

  logic [2:0] current_row;
  logic [2:0] drain_row;
  logic [7:0] debounce_count;
  logic [7:0] button_levels   [ROW_COUNT];
  logic [7:0] pending_changes [ROW_COUNT];
  logic [7:0] led_store       [ROW_COUNT];

  logic       out_free;
  logic [3:0] row_inc;
  logic [2:0] scan_row;
  logic [2:0] lvl_row;
  logic [7:0] lvl_byte;
  logic [7:0] pend_byte;
  logic [2:0] led_row;
  logic [7:0] led_byte;
  logic [7:0] changed;
  logic [7:0] count_dec;
  logic [2:0] pin;
  logic [7:0] pend_rest;
  logic       later_pending;
  logic       drain_step;
  logic       emit_event;
  logic       event_last;

  assign out_free = !result_valid || !result_stall;
  assign row_inc  = {1'b0, current_row} + 4'd1;
  assign scan_row = (row_inc >= 4'(ROW_COUNT)) ? 3'd0 : row_inc[2:0];
  assign lvl_row  = (state == BK_DRAIN) ? drain_row : scan_row;
  assign lvl_byte  = button_levels[lvl_row];
  assign pend_byte = pending_changes[lvl_row];
  assign led_row   = (cmd.kind == CMD_SCAN) ? scan_row : cmd.row;
  assign led_byte  = led_store[led_row];
  assign changed   = cmd.sample ^ lvl_byte;
  assign count_dec = (debounce_count != 8'd0) ? debounce_count - 8'd1 : 8'd0;

  always_comb begin
    pin = 3'd0;
    for (int i = COL_COUNT - 1; i >= 0; i--) begin
      if (pend_byte[i]) begin
        pin = 3'(i);
      end
    end
  end

  always_comb begin
    later_pending = 1'b0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      if ((r > int'(drain_row)) && (pending_changes[r] != 8'd0)) begin
        later_pending = 1'b1;
      end
    end
  end

  assign pend_rest  = pend_byte & ~(8'd1 << pin);
  assign event_last = (pend_rest == 8'd0) && !later_pending;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    drain_step = 1'b0;
    emit_event = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          pop = 1'b1;
          if (cmd.kind == CMD_DRAIN) begin
            state_next = BK_DRAIN;
          end
        end
      end
      BK_DRAIN: begin
        if (out_free) begin
          if (pend_byte == 8'd0) begin
            drain_step = 1'b1;
            if (drain_row == ROW_LAST) begin
              state_next = BK_IDLE;
            end
          end else begin
            emit_event = 1'b1;
            if (event_last) begin
              state_next = BK_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      current_row    <= 3'd0;
      drain_row      <= 3'd0;
      debounce_count <= 8'd0;
      for (int r = 0; r < ROW_COUNT; r++) begin
        button_levels[r]   <= 8'hff;
        pending_changes[r] <= 8'd0;
        led_store[r]       <= 8'd0;
      end
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        case (cmd.kind)
          CMD_SCAN: begin
            current_row  <= scan_row;
            result_valid <= 1'b1;
            row_select   <= 8'd1 << scan_row;
            led_columns  <= led_byte;
            event_valid  <= 1'b0;
            button_index <= 6'd0;
            button_level <= 1'b0;
            read_data    <= 1'b0;
            last         <= 1'b1;
            if (count_dec == 8'd0) begin
              pending_changes[scan_row] <= pend_byte | changed;
              button_levels[scan_row]   <= cmd.sample;
              debounce_count            <= (changed != 8'd0) ? reload : 8'd0;
            end else begin
              debounce_count <= count_dec;
            end
          end
          CMD_SET_PIN: begin
            if (cmd.in_range) begin
              led_store[cmd.row][cmd.col] <= cmd.led_bit;
            end
          end
          CMD_SET_ROW: begin
            if (cmd.in_range) begin
              led_store[cmd.row] <= cmd.row_value;
            end
          end
          CMD_DRAIN: begin
            drain_row <= 3'd0;
          end
          CMD_READ_PIN: begin
            result_valid <= 1'b1;
            row_select   <= 8'd0;
            led_columns  <= 8'd0;
            event_valid  <= 1'b0;
            button_index <= 6'd0;
            button_level <= 1'b0;
            read_data    <= cmd.in_range & led_byte[cmd.col];
            last         <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (drain_step) begin
        drain_row <= drain_row + 3'd1;
      end
      if (emit_event) begin
        pending_changes[drain_row][pin] <= 1'b0;
        result_valid <= 1'b1;
        row_select   <= 8'd0;
        led_columns  <= 8'd0;
        event_valid  <= 1'b1;
        button_index <= {drain_row, map_col(reversed, drain_row, pin)};
        button_level <= lvl_byte[pin];
        read_data    <= 1'b0;
        last         <= event_last;
      end
    end
  end

endmodule

@@ hw/rtl/button_led_matrix_scanner.sv @@
// Scanner for an 8x8 button and LED matrix with a shared debounce counter.
// Requests come in on the item channel (item_valid, item_stall) and are
// buffered in a two-entry queue; item_stall is high only while that queue is
// full. Results leave on the result channel (result_valid, result_stall)
// from an output register, which holds its contents while result_stall is
// high; requests are still taken into the queue until it fills.
// A scan tick or an LED read gives its registered result in the cycle after
// the request is taken from the queue; an accepted request is first written
// into a queue entry. LED writes give no result. While the result channel is
// not stalled the back end takes one such request per cycle.
// A drain, once started, gives one event per pending button, row by row, and
// steps past each row that has none left; it ends on its last event or after
// the last row, and no other request is taken from the queue until it ends.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
// Reset clears the queue, selects row zero, sets all button levels high,
// clears pending changes and LEDs, and loads the default configuration.
module button_led_matrix_scanner
  import blm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] action,
  input  logic [7:0] column_sample,
  input  logic [5:0] led_index,
  input  logic       led_value,
  input  logic [2:0] row_index,
  input  logic [7:0] row_value,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] row_select,
  output logic [7:0] led_columns,
  output logic       event_valid,
  output logic [5:0] button_index,
  output logic       button_level,
  output logic       read_data,
  output logic       last
);

  logic [7:0] debounce_reload;
  logic       right_half_reversed;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       head_valid;
  cmd_t       push_cmd;
  cmd_t       head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_reload     <= RELOAD_RESET;
      right_half_reversed <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RELOAD:   debounce_reload     <= cfg_data;
        CFG_REVERSED: right_half_reversed <= cfg_data[0];
      endcase
    end
  end

  blm_front u_front (
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .column_sample (column_sample),
    .led_index     (led_index),
    .led_value     (led_value),
    .row_index     (row_index),
    .row_value     (row_value),
    .reversed      (right_half_reversed),
    .queue_full    (queue_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  blm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  blm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd          (head_cmd),
    .pop          (pop),
    .reload       (debounce_reload),
    .reversed     (right_half_reversed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row_select   (row_select),
    .led_columns  (led_columns),
    .event_valid  (event_valid),
    .button_index (button_index),
    .button_level (button_level),
    .read_data    (read_data),
    .last         (last)
  );

  a_row_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(row_select))
    else $error("row select is not one-hot");

  a_event_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_valid |-> (row_select == 8'd0) && (led_columns == 8'd0) && !read_data)
    else $error("event result carries scan or read data");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !event_valid |-> last)
    else $error("scan or read result is not marked last");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import blm_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_TAIL = 100;
  localparam int STUCK_LIMIT = 2000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] sample;
    logic [5:0] led_idx;
    logic       led_val;
    logic [2:0] row_idx;
    logic [7:0] row_val;
  } request_t;

  typedef struct packed {
    logic [7:0] row_sel;
    logic [7:0] led_cols;
    logic       ev;
    logic [5:0] btn;
    logic       lvl;
    logic       rd;
    logic       fin;
  } result_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       item_valid;
  logic       item_stall;
  logic [2:0] action;
  logic [7:0] column_sample;
  logic [5:0] led_index;
  logic       led_value;
  logic [2:0] row_index;
  logic [7:0] row_value;
  logic       result_valid;
  logic       result_stall;
  logic [7:0] row_select;
  logic [7:0] led_columns;
  logic       event_valid;
  logic [5:0] button_index;
  logic       button_level;
  logic       read_data;
  logic       last;

  int         scan_row;
  bit [7:0]   levels [ROW_COUNT];
  bit [7:0]   pending [ROW_COUNT];
  bit [7:0]   hold_count;
  bit [7:0]   leds [ROW_COUNT];
  bit [7:0]   reload_value;
  bit         mirror_right;

  result_t    expected_results [$];
  int         errors;
  int         stuck_cycles;
  bit         quiet;

  button_led_matrix_scanner uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int mirrored_column(int row, int col);
    if (mirror_right && row >= 4) begin
      return 7 - col;
    end
    return col;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic request_t make_request(logic [2:0] act, logic [7:0] smp, logic [5:0] idx,
                                            logic val, logic [2:0] row, logic [7:0] rval);
    request_t r;
    r.action  = act;
    r.sample  = smp;
    r.led_idx = idx;
    r.led_val = val;
    r.row_idx = row;
    r.row_val = rval;
    return r;
  endfunction

  function automatic int next_row();
    return (scan_row + 1 >= ROW_COUNT) ? 0 : scan_row + 1;
  endfunction

  task automatic reset_matrix_state();
    scan_row = 0;
    hold_count = '0;
    for (int i = 0; i < ROW_COUNT; i++) begin
      levels[i] = 8'hff;
      pending[i] = '0;
      leds[i] = '0;
    end
    reload_value = RELOAD_RESET;
    mirror_right = 1'b0;
  endtask

  task automatic predict_request(input request_t r);
    result_t e;
    result_t batch [$];
    int row;
    int col;
    bit [7:0] changed;
    e = '0;
    case (r.action)
      ACT_SCAN: begin
        row = next_row();
        scan_row = row;
        e.row_sel = 8'h01 << row;
        e.led_cols = leds[row];
        e.fin = 1'b1;
        expected_results.push_back(e);
        if (hold_count != 0) begin
          hold_count--;
        end
        changed = r.sample ^ levels[row];
        if (hold_count == 0) begin
          pending[row] |= changed;
          levels[row] = r.sample;
          if (changed != 0) begin
            hold_count = reload_value;
          end
        end
      end
      ACT_SET_PIN: begin
        row = r.led_idx >> 3;
        if (row < ROW_COUNT) begin
          col = mirrored_column(row, r.led_idx[2:0]);
          leds[row][col] = r.led_val;
        end
      end
      ACT_SET_ROW: begin
        row = r.row_idx;
        if (row < ROW_COUNT) begin
          leds[row] = (mirror_right && row >= 4) ? reverse8(r.row_val) : r.row_val;
        end
      end
      ACT_DRAIN: begin
        for (int rr = 0; rr < ROW_COUNT; rr++) begin
          for (int p = 0; p < 8; p++) begin
            if (pending[rr][p]) begin
              e = '0;
              e.ev = 1'b1;
              e.btn = 6'(8 * rr + mirrored_column(rr, p));
              e.lvl = levels[rr][p];
              batch.push_back(e);
            end
          end
          pending[rr] = '0;
        end
        if (batch.size() > 0) begin
          batch[batch.size() - 1].fin = 1'b1;
        end
        foreach (batch[i]) begin
          expected_results.push_back(batch[i]);
        end
      end
      ACT_READ_PIN: begin
        row = r.led_idx >> 3;
        if (row < ROW_COUNT) begin
          e.rd = leds[row][mirrored_column(row, r.led_idx[2:0])];
        end
        e.fin = 1'b1;
        expected_results.push_back(e);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= r.action;
    column_sample <= r.sample;
    led_index <= r.led_idx;
    led_value <= r.led_val;
    row_index <= r.row_idx;
    row_value <= r.row_val;
    do @(posedge clk); while (item_stall);
    predict_request(r);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] data);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RELOAD) begin
      reload_value = data;
    end else begin
      mirror_right = data[0];
    end
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    int row;
    r = make_request(ACT_SCAN, 8'($urandom), 6'($urandom), 1'($urandom), 3'($urandom),
                     8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.action = ACT_SCAN;
      row = next_row();
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        r.sample = levels[row];
      end else if (pick < 9) begin
        r.sample = levels[row] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (pick < 57) begin
      r.action = ACT_SET_PIN;
    end else if (pick < 67) begin
      r.action = ACT_SET_ROW;
    end else if (pick < 80) begin
      r.action = ACT_DRAIN;
    end else if (pick < 95) begin
      r.action = ACT_READ_PIN;
    end else begin
      r.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end
    return r;
  endfunction

  task automatic test_led_access();
    send_request(make_request(ACT_SET_ROW, 8'h00, 6'd0, 1'b0, 3'd1, 8'ha5));
    send_request(make_request(ACT_SET_PIN, 8'h00, 6'd63, 1'b1, 3'd0, 8'h00));
    send_request(make_request(ACT_SET_PIN, 8'h00, 6'd0, 1'b1, 3'd0, 8'h00));
    send_request(make_request(ACT_SCAN, 8'hff, 6'd0, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_READ_PIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_READ_PIN, 8'h00, 6'd63, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_UNUSED_HI, 8'hff, 6'd63, 1'b1, 3'd7, 8'hff));
  endtask

  task automatic test_mirrored_leds();
    write_register(CFG_REVERSED, 8'h01);
    write_register(CFG_RELOAD, 8'h00);
    send_request(make_request(ACT_SET_ROW, 8'h00, 6'd0, 1'b0, 3'd7, 8'h01));
    send_request(make_request(ACT_SET_PIN, 8'h00, 6'd39, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_READ_PIN, 8'h00, 6'd63, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_READ_PIN, 8'h00, 6'd56, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_READ_PIN, 8'h00, 6'd39, 1'b0, 3'd0, 8'h00));
  endtask

  // Every button on every row changes once, so the drain returns all 64 events.
  task automatic test_full_drain();
    for (int i = 0; i < ROW_COUNT; i++) begin
      send_request(make_request(ACT_SCAN, ~levels[next_row()], 6'd0, 1'b0, 3'd0, 8'h00));
    end
    send_request(make_request(ACT_DRAIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
    send_request(make_request(ACT_DRAIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
  endtask

  task automatic test_random_mix(input int count, input logic [7:0] reload, input bit mirror,
                                 input bit calm_start);
    write_register(CFG_RELOAD, reload);
    write_register(CFG_REVERSED, {7'd0, mirror});
    for (int i = 0; i < count; i++) begin
      quiet = calm_start && i < 20;
      send_request(random_request());
    end
    quiet = 1'b0;
  endtask

  task automatic test_long_debounce();
    write_register(CFG_RELOAD, 8'hff);
    write_register(CFG_REVERSED, 8'h00);
    send_request(make_request(ACT_SCAN, levels[next_row()] ^ 8'h01, 6'd0, 1'b0, 3'd0,
                              8'h00));
    for (int i = 0; i < 10; i++) begin
      send_request(make_request(ACT_SCAN, 8'($urandom), 6'd0, 1'b0, 3'd0, 8'h00));
    end
    send_request(make_request(ACT_DRAIN, 8'h00, 6'd0, 1'b0, 3'd0, 8'h00));
  endtask

  initial begin
    int hold;
    int r;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        hold = (r < 70) ? $urandom_range(0, 1) : (r < 95) ? $urandom_range(2, 5) :
               $urandom_range(14, 39);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {row_select, led_columns, event_valid, button_index, button_level, read_data, last};
      if (expected_results.size() == 0) begin
        if (errors < REPORT_MAX) begin
          $display("unexpected result: sel=%h cols=%h ev=%b idx=%0d lvl=%b rd=%b last=%b",
                   got.row_sel, got.led_cols, got.ev, got.btn, got.lvl, got.rd, got.fin);
        end
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          if (errors < REPORT_MAX) begin
            $display("mismatch: expected sel=%h cols=%h ev=%b idx=%0d lvl=%b rd=%b last=%b",
                     want.row_sel, want.led_cols, want.ev, want.btn, want.lvl, want.rd,
                     want.fin);
            $display("          actual   sel=%h cols=%h ev=%b idx=%0d lvl=%b rd=%b last=%b",
                     got.row_sel, got.led_cols, got.ev, got.btn, got.lvl, got.rd, got.fin);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    quiet = 1'b0;
    stuck_cycles <= 0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RELOAD;
    cfg_data <= '0;
    item_valid <= 1'b0;
    action <= ACT_SCAN;
    column_sample <= '0;
    led_index <= '0;
    led_value <= 1'b0;
    row_index <= '0;
    row_value <= '0;
    reset_matrix_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_led_access();
    test_mirrored_leds();
    test_full_drain();
    test_random_mix(70, 8'd2, 1'b0, 1'b1);
    test_random_mix(70, 8'd0, 1'b1, 1'b0);
    test_random_mix(70, 8'd10, 1'b0, 1'b1);
    test_random_mix(70, 8'd1, 1'b1, 1'b0);
    test_long_debounce();

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    errors += expected_results.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
